// File: sv/bcbf_pkg.sv
// Shared types, constants and arithmetic helpers for the biquad cascade band-pass filter.
package bcbf_pkg;

  localparam int NUM_SECTIONS = 4;
  localparam int SEC_W        = $clog2(NUM_SECTIONS);

  typedef logic [SEC_W-1:0] sec_t;

  localparam sec_t SEC_FIRST = sec_t'(0);
  localparam sec_t SEC_LAST  = sec_t'(NUM_SECTIONS - 1);
  // Section whose middle numerator tap is +2; the later sections use -2.
  localparam sec_t SEC_PLUS2 = sec_t'(1);

  // Request action codes.
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Feedback coefficients a1 and a2 per section, rounded to 30 fraction bits.
  localparam logic signed [31:0] A1_Q30 [NUM_SECTIONS] = '{
    -32'sd592655934, -32'sd923810550, -32'sd401227684, -32'sd1241258165
  };
  localparam logic signed [31:0] A2_Q30 [NUM_SECTIONS] = '{
    32'sd649202711, 32'sd681954413, 32'sd872401359, 32'sd910120632
  };
  // Gain taps of the first section.
  localparam logic signed [31:0] B0_Q30 = 32'sd2399695;
  localparam logic signed [31:0] B1_Q30 = 32'sd4799390;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_MUL,
    ST_W_CALC,
    ST_FF_MUL,
    ST_Y_CALC,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul_fb;
    logic calc_w;
    logic mul_ff;
    logic calc_y;
    logic out_load;
    sec_t sec;
  } ctrl_cmd_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Round half up, shift right arithmetically, then saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v,
                                                 input int sh);
    logic signed [65:0] t;
    if (sh == 0) begin
      t = v;
    end else begin
      t = (v + (66'sd1 <<< (sh - 1))) >>> sh;
    end
    return sat32(t);
  endfunction

  // Re-round a 30 fraction bit coefficient to cbits fraction bits.
  function automatic logic signed [31:0] coef_scale(input logic signed [31:0] c30,
                                                    input int cbits);
    logic signed [32:0] t;
    int sh;
    sh = 30 - cbits;
    if (sh == 0) begin
      t = {c30[31], c30};
    end else begin
      t = ({c30[31], c30} + (33'sd1 <<< (sh - 1))) >>> sh;
    end
    return t[31:0];
  endfunction

endpackage

// File: sv/bcbf_in_if.sv
// Request channel carrying the action and the input sample.
interface bcbf_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] sample;

  modport source (output valid, output action, output sample, input ready);
  modport sink   (input valid, input action, input sample, output ready);
endinterface

// File: sv/bcbf_out_if.sv
// Result channel carrying the filtered value.
interface bcbf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// File: sv/biquad_cascade_bandpass_filter_unit.sv
// Top level of the eighth-order biquad cascade band-pass filter.
// A request is taken only in the idle state, which the unit reenters once the last
// result is in the output register. The first section steps through feedback
// products, w, feed-forward products and output, the others skip feed-forward
// products; all share two multipliers. A clear request stays idle and gives no result.
// Reset (rst, synchronous, active high) zeroes all delay values and drops valid.
module biquad_cascade_bandpass_filter_unit #(
  parameter int STATE_FRAC_BITS = 12,
  parameter int COEF_FRAC_BITS  = 30
) (
  input logic        clk,
  input logic        rst,
  bcbf_in_if.sink    sample_ch,
  bcbf_out_if.source result_ch
);

  // Command bundle from the sequencer to the datapath. The sequencer also
  // owns the result valid flag, so a finished result can sit in the output
  // register while the next request is already being accepted.
  bcbf_pkg::ctrl_cmd_t cmd;

  bcbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_ch.valid),
    .in_action (sample_ch.action),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .cmd       (cmd)
  );

  // The datapath holds the eight delay values, the running section value,
  // the two product registers and the output register.
  bcbf_dp #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sample   (sample_ch.sample),
    .filtered (result_ch.filtered)
  );

`ifndef SYNTHESIS
  // The datapath must never see two operations in the same cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.clear, cmd.mul_fb, cmd.calc_w, cmd.mul_ff, cmd.calc_y,
              cmd.out_load}))
    else $error("datapath commands overlap");

  // Feed-forward products belong to the gain section only.
  a_ff_first: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_ff |-> (cmd.sec == bcbf_pkg::SEC_FIRST))
    else $error("feed-forward multiply outside the first section");

  // An accepted filter request starts the first section in the next cycle.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready && sample_ch.action == bcbf_pkg::ACT_FILTER) |=>
      (cmd.mul_fb && cmd.sec == bcbf_pkg::SEC_FIRST))
    else $error("filter request did not start the first section");

  // A clear request never produces a result.
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready && sample_ch.action == bcbf_pkg::ACT_CLEAR) |=>
      !cmd.out_load)
    else $error("clear request produced a result");
`endif

endmodule

// File: sv/bcbf_ctrl.sv
// Sequencer that steps the datapath through the four biquad sections.
module bcbf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcbf_pkg::ctrl_cmd_t  cmd
);

  bcbf_pkg::ctrl_state_t state, state_next;
  bcbf_pkg::sec_t        sec, sec_next;
  logic                  out_valid_next;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bcbf_pkg::ST_IDLE;
      sec       <= bcbf_pkg::SEC_FIRST;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sec       <= sec_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == bcbf_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    sec_next       = sec;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.sec        = sec;
    unique case (state)
      bcbf_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == bcbf_pkg::ACT_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            sec_next   = bcbf_pkg::SEC_FIRST;
            state_next = bcbf_pkg::ST_FB_MUL;
          end
        end
      end
      bcbf_pkg::ST_FB_MUL: begin
        cmd.mul_fb = 1'b1;
        state_next = bcbf_pkg::ST_W_CALC;
      end
      bcbf_pkg::ST_W_CALC: begin
        cmd.calc_w = 1'b1;
        state_next = (sec == bcbf_pkg::SEC_FIRST) ? bcbf_pkg::ST_FF_MUL
                                                  : bcbf_pkg::ST_Y_CALC;
      end
      bcbf_pkg::ST_FF_MUL: begin
        cmd.mul_ff = 1'b1;
        state_next = bcbf_pkg::ST_Y_CALC;
      end
      bcbf_pkg::ST_Y_CALC: begin
        cmd.calc_y = 1'b1;
        if (sec == bcbf_pkg::SEC_LAST) begin
          state_next = bcbf_pkg::ST_DONE;
        end else begin
          sec_next   = sec + bcbf_pkg::sec_t'(1);
          state_next = bcbf_pkg::ST_FB_MUL;
        end
      end
      bcbf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bcbf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bcbf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bcbf_dp.sv
// Datapath: delay registers, two shared multipliers, rounding and saturation.
module bcbf_dp #(
  parameter int STATE_FRAC_BITS = 12,
  parameter int COEF_FRAC_BITS  = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  bcbf_pkg::ctrl_cmd_t cmd,
  input  logic signed [15:0]  sample,
  output logic signed [31:0]  filtered
);

  localparam int N = bcbf_pkg::NUM_SECTIONS;

  logic signed [31:0] z1 [N];
  logic signed [31:0] z2 [N];
  logic signed [31:0] val;
  logic signed [31:0] w;
  logic signed [65:0] p1, p2;

  logic signed [31:0] a1_tab [N];
  logic signed [31:0] a2_tab [N];
  logic signed [31:0] b0, b1;

  for (genvar g = 0; g < N; g++) begin : g_coef
    assign a1_tab[g] = bcbf_pkg::coef_scale(bcbf_pkg::A1_Q30[g], COEF_FRAC_BITS);
    assign a2_tab[g] = bcbf_pkg::coef_scale(bcbf_pkg::A2_Q30[g], COEF_FRAC_BITS);
  end
  assign b0 = bcbf_pkg::coef_scale(bcbf_pkg::B0_Q30, COEF_FRAC_BITS);
  assign b1 = bcbf_pkg::coef_scale(bcbf_pkg::B1_Q30, COEF_FRAC_BITS);

  logic signed [31:0] z1_s, z2_s;
  logic signed [31:0] ma1, ma2;
  logic signed [32:0] mb1, mb2;
  logic signed [65:0] scaled, acc_w, acc_y0, tap_y, mid;

  assign z1_s = z1[cmd.sec];
  assign z2_s = z2[cmd.sec];

  always_comb begin
    // The first section's outer taps share b0, so b0*w + b0*z2 is one product.
    if (cmd.mul_ff) begin
      ma1 = b0;
      mb1 = 33'(w) + 33'(z2_s);
      ma2 = b1;
      mb2 = 33'(z1_s);
    end else begin
      ma1 = a1_tab[cmd.sec];
      mb1 = 33'(z1_s);
      ma2 = a2_tab[cmd.sec];
      mb2 = 33'(z2_s);
    end
    scaled = 66'(sample) <<< STATE_FRAC_BITS;
    acc_w  = (66'(val) <<< COEF_FRAC_BITS) - p1 - p2;
    acc_y0 = p1 + p2;
    mid    = 66'(z1_s) <<< 1;
    if (cmd.sec == bcbf_pkg::SEC_PLUS2) begin
      tap_y = 66'(w) + mid + 66'(z2_s);
    end else begin
      tap_y = 66'(w) - mid + 66'(z2_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        z1[i] <= '0;
        z2[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < N; i++) begin
        z1[i] <= '0;
        z2[i] <= '0;
      end
    end else if (cmd.calc_y) begin
      z2[cmd.sec] <= z1_s;
      z1[cmd.sec] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val <= bcbf_pkg::sat32(scaled);
    end else if (cmd.calc_y) begin
      if (cmd.sec == bcbf_pkg::SEC_FIRST) begin
        val <= bcbf_pkg::rnd_sat(acc_y0, COEF_FRAC_BITS);
      end else begin
        val <= bcbf_pkg::sat32(tap_y);
      end
    end
    if (cmd.mul_fb || cmd.mul_ff) begin
      p1 <= 66'(ma1) * 66'(mb1);
      p2 <= 66'(ma2) * 66'(mb2);
    end
    if (cmd.calc_w) begin
      w <= bcbf_pkg::rnd_sat(acc_w, COEF_FRAC_BITS);
    end
    if (cmd.out_load) begin
      filtered <= val;
    end
  end

endmodule

// File: test/biquad_cascade_bandpass_filter_unit_test.sv
// Self-checking testbench for the eighth-order biquad cascade band-pass filter unit.
module biquad_cascade_bandpass_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The unit is built with its default fixed-point formats, and the predictor
  // below uses the same values.
  localparam int STATE_FRAC = 12;
  localparam int COEF_FRAC  = 30;

  // A filter request has its result in the output register before the next request
  // is taken, so a short tail after the last result is enough to catch any stray output.
  localparam int DRAIN_CYCLES   = 40;
  // The slowest correct gap between two handshakes is made of the stall bursts on
  // both sides plus the walk through the sections of one request, so this limit
  // only trips on a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Wide accumulator: every product sum of the predictor fits without loss.
  typedef logic signed [71:0] acc_t;

  localparam acc_t WORD_MAX = 72'sd2147483647;
  localparam acc_t WORD_MIN = -72'sd2147483648;

  logic clk = 1'b0;
  logic rst;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bcbf_in_if  sample_ch ();
  bcbf_out_if result_ch ();

  biquad_cascade_bandpass_filter_unit #(
    .STATE_FRAC_BITS (STATE_FRAC),
    .COEF_FRAC_BITS  (COEF_FRAC)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Predictor state: the two delay values of every section, kept apart from
  // the unit and updated in request order at the moment of acceptance.
  logic signed [31:0] delay_z1 [bcbf_pkg::NUM_SECTIONS];
  logic signed [31:0] delay_z2 [bcbf_pkg::NUM_SECTIONS];

  // Filtered values still owed by the unit, oldest first.
  logic signed [31:0] filtered_expected [$];

  // When set, both the request side and the result side insert random stalls.
  bit idling_on;

  int error_count;
  int filter_count;
  int clear_count;
  int result_count;

  // Rounds half up (towards plus infinity at exactly one half) while dropping
  // sh fraction bits. An arithmetic shift of the biased value gives the floor,
  // which is the correct rounding for negative values as well.
  function automatic acc_t round_half_up(input acc_t v, input int sh);
    if (sh == 0) begin
      return v;
    end
    return (v + (acc_t'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Clamps a wide value into the signed 32-bit range.
  function automatic logic signed [31:0] clamp_word(input acc_t v);
    if (v > WORD_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < WORD_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // The coefficients are held with 30 fraction bits; a narrower coefficient
  // format re-rounds them once more.
  function automatic acc_t scaled_coef(input logic signed [31:0] c30);
    return round_half_up(acc_t'(c30), 30 - COEF_FRAC);
  endfunction

  function automatic void clear_delays();
    for (int s = 0; s < bcbf_pkg::NUM_SECTIONS; s++) begin
      delay_z1[s] = '0;
      delay_z2[s] = '0;
    end
  endfunction

  // Runs one sample through the four direct-form-II sections and returns the
  // band-pass output. Each section forms w from its input and its feedback
  // taps, then y from w and the old delays, and finally shifts its delay line.
  function automatic logic signed [31:0] bandpass_output(input logic signed [15:0] smp);
    logic signed [31:0] stage_val;
    logic signed [31:0] w;
    logic signed [31:0] z1;
    logic signed [31:0] z2;
    acc_t acc;
    acc_t b0;
    stage_val = clamp_word(acc_t'(smp) <<< STATE_FRAC);
    b0 = scaled_coef(bcbf_pkg::B0_Q30);
    for (int s = 0; s < bcbf_pkg::NUM_SECTIONS; s++) begin
      z1 = delay_z1[s];
      z2 = delay_z2[s];
      acc = (acc_t'(stage_val) <<< COEF_FRAC)
            - scaled_coef(bcbf_pkg::A1_Q30[s]) * acc_t'(z1)
            - scaled_coef(bcbf_pkg::A2_Q30[s]) * acc_t'(z2);
      w = clamp_word(round_half_up(acc, COEF_FRAC));
      if (s == int'(bcbf_pkg::SEC_FIRST)) begin
        // The gain section is the only one with fractional numerator taps.
        acc = b0 * acc_t'(w) + scaled_coef(bcbf_pkg::B1_Q30) * acc_t'(z1)
              + b0 * acc_t'(z2);
        stage_val = clamp_word(round_half_up(acc, COEF_FRAC));
      end else if (s == int'(bcbf_pkg::SEC_PLUS2)) begin
        stage_val = clamp_word(acc_t'(w) + 2 * acc_t'(z1) + acc_t'(z2));
      end else begin
        stage_val = clamp_word(acc_t'(w) - 2 * acc_t'(z1) + acc_t'(z2));
      end
      delay_z2[s] = z1;
      delay_z1[s] = w;
    end
    return stage_val;
  endfunction

  // Mostly full-range noise, with a share of small values and of full-scale
  // extremes so that both the quiet and the saturating corners are visited.
  function automatic logic signed [15:0] random_sample();
    logic signed [15:0] smp;
    case ($urandom_range(0, 9))
      0: begin
        smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      1, 2: begin
        smp = 16'($urandom_range(0, 511)) - 16'sd256;
      end
      default: begin
        smp = 16'($urandom);
      end
    endcase
    return smp;
  endfunction

  // Presents one request and waits for its handshake. With idling on, the
  // request line may first go quiet for a random burst, during which the
  // payload carries junk. The expected result is worked out at the edge
  // where the request is taken, so the predictor follows request order.
  task automatic send_request(input logic act, input logic signed [15:0] smp);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      sample_ch.valid  <= 1'b0;
      sample_ch.action <= logic'($urandom_range(0, 1));
      sample_ch.sample <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.action <= act;
    sample_ch.sample <= smp;
    do begin
      @(posedge clk);
    end while (!(sample_ch.valid && sample_ch.ready));
    if (act == bcbf_pkg::ACT_CLEAR) begin
      clear_delays();
      clear_count++;
    end else begin
      filtered_expected.push_back(bandpass_output(smp));
      filter_count++;
    end
  endtask

  // Drops the request line and holds it low until every owed result is back.
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    while (filtered_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Short directed run: a clear straight out of reset, the sample extremes,
  // alternating bit patterns, full-scale swings that push the sections
  // towards saturation, clears with a non-zero sample and two clears in a row.
  task automatic test_directed_extremes();
    idling_on = 1'b0;
    send_request(bcbf_pkg::ACT_CLEAR, 16'sh7FFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh0000);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh7FFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh8000);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh7FFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh8000);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh0001);
    send_request(bcbf_pkg::ACT_FILTER, 16'shFFFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh5555);
    send_request(bcbf_pkg::ACT_FILTER, 16'shAAAA);
    send_request(bcbf_pkg::ACT_CLEAR, 16'sh8000);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh7FFF);
    send_request(bcbf_pkg::ACT_CLEAR, 16'sh0000);
    send_request(bcbf_pkg::ACT_CLEAR, 16'shFFFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh8000);
    repeat (6) send_request(bcbf_pkg::ACT_FILTER, 16'sh7FFF);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh8000);
    send_request(bcbf_pkg::ACT_FILTER, 16'sh8000);
    send_request(bcbf_pkg::ACT_CLEAR, 16'sh1234);
  endtask

  // Bulk random traffic in segments. Most segments are square waves of
  // random period and amplitude, which excite the resonances of the band
  // and drive the delay values hard; the rest are random samples. Clears
  // are scattered throughout, and each segment picks afresh whether the
  // two sides stall, so stretches of clean streaming occur as well.
  task automatic test_random_traffic(input int target);
    int sent;
    int kind;
    int seg_len;
    int period;
    int amp;
    logic signed [15:0] smp;
    sent = 0;
    while (sent < target) begin
      idling_on = ($urandom_range(0, 3) != 0);
      kind      = $urandom_range(0, 9);
      seg_len   = $urandom_range(10, 60);
      period    = $urandom_range(2, 48);
      amp       = $urandom_range(1, 32767);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 63) == 0) begin
          send_request(bcbf_pkg::ACT_CLEAR, random_sample());
        end else begin
          if (kind < 6) begin
            smp = 16'(amp);
            if ((i % period) >= period / 2) begin
              smp = -smp;
            end
          end else begin
            smp = random_sample();
          end
          send_request(bcbf_pkg::ACT_FILTER, smp);
        end
      end
      sent += seg_len;
    end
  endtask

  // Short bursts, each followed by a full pause until the unit has handed
  // back every result, so the pipeline empties and restarts cold.
  task automatic test_drain_pauses();
    idling_on = 1'b1;
    for (int burst = 0; burst < 4; burst++) begin
      repeat ($urandom_range(1, 12)) begin
        send_request(bcbf_pkg::ACT_FILTER, random_sample());
      end
      wait_for_results();
    end
  endtask

  // Closing stretch with no stalls on either side, at the unit's full rate.
  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        send_request(bcbf_pkg::ACT_CLEAR, random_sample());
      end else begin
        send_request(bcbf_pkg::ACT_FILTER, random_sample());
      end
    end
  endtask

  // The result side is always ready unless idling is on, in which case it
  // stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted result is compared with the oldest owed filtered value.
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      result_count++;
      if (filtered_expected.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("[%0t] unexpected result: filtered %0d (0x%08h) with nothing owed",
                   $realtime, result_ch.filtered, result_ch.filtered);
        end
      end else if (result_ch.filtered !== filtered_expected[0]) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("[%0t] mismatch on filtered: expected %0d (0x%08h), got %0d (0x%08h)",
                   $realtime, filtered_expected[0], filtered_expected[0],
                   result_ch.filtered, result_ch.filtered);
        end
        void'(filtered_expected.pop_front());
      end else begin
        void'(filtered_expected.pop_front());
      end
    end
  end

  // Watchdog: ends the run if neither a request nor a result is taken for
  // too long once reset has been released.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_ch.valid && sample_ch.ready) ||
          (result_ch.valid && result_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, filtered_expected.size());
    $display("** biquad_cascade_bandpass_filter_unit: FAILED **");
    $finish;
  end

  // Main sequence: reset once, then the tests in turn, then the drain and
  // the verdict.
  initial begin
    error_count  = 0;
    filter_count = 0;
    clear_count  = 0;
    result_count = 0;
    idling_on    = 1'b0;
    clear_delays();
    rst              <= 1'b1;
    sample_ch.valid  <= 1'b0;
    sample_ch.action <= bcbf_pkg::ACT_FILTER;
    sample_ch.sample <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_random_traffic(1380);
    test_drain_pauses();
    test_back_to_back(260);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d filter requests and %0d clear requests; %0d results checked.",
             filter_count, clear_count, result_count);
    $display("Stimulus: sample extremes, square-wave bursts, random noise, stalls on both sides.");
    if (error_count == 0) begin
      $display("** biquad_cascade_bandpass_filter_unit: PASSED **");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("** biquad_cascade_bandpass_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: biquad_cascade_bandpass_filter_unit.f
sv/bcbf_pkg.sv
sv/bcbf_in_if.sv
sv/bcbf_out_if.sv
sv/bcbf_ctrl.sv
sv/bcbf_dp.sv
sv/biquad_cascade_bandpass_filter_unit.sv
test/biquad_cascade_bandpass_filter_unit_test.sv
